### sv/atbp_pkg.sv
// shared types, constants and helpers of the adaptive threshold beat picker
package atbp_pkg;

  localparam int DATA_W  = 32;
  localparam int COEF_W  = 17;
  localparam int PROD_W  = DATA_W + COEF_W;
  localparam int HOPS_W  = 16;
  localparam int MBI_W   = 10;
  localparam int DECAY_W = 16;
  localparam int CFG_W   = 16;

  // fraction bits of the onset format; only the quiet limit follows from it
  localparam int FRAC_BITS = 16;
  localparam logic [DATA_W-1:0] SMALL_LIMIT =
    DATA_W'(((2 ** FRAC_BITS) + 999999) / 1000000);

  // coefficients, unsigned q0.16 / q1.16
  localparam logic [COEF_W-1:0] ALPHA_C     = COEF_W'(5243);
  localparam logic [COEF_W-1:0] ONE_MIN_A_C = COEF_W'(60293);
  localparam logic [COEF_W-1:0] PEAK_C      = COEF_W'(22938);
  localparam logic [COEF_W-1:0] DEV_C       = COEF_W'(117965);

  localparam logic [MBI_W-1:0]   MBI_RESET   = MBI_W'(24);
  localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(63570);

  // register indexes
  localparam logic CFG_MBI   = 1'b0;
  localparam logic CFG_DECAY = 1'b1;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP  = 4'd0;
  localparam op_t OP_MA   = 4'd1;  // product mean * (1 - alpha)
  localparam op_t OP_XA   = 4'd2;  // product onset * alpha
  localparam op_t OP_MEAN = 4'd3;  // new mean, product dev * (1 - alpha)
  localparam op_t OP_DA   = 4'd4;  // product diff * alpha
  localparam op_t OP_DEV  = 4'd5;  // new dev, product held * decay
  localparam op_t OP_HELD = 4'd6;  // new held peak, product dev * 1.8
  localparam op_t OP_DYN  = 4'd7;  // dynamic threshold, product held * 0.35
  localparam op_t OP_THR  = 4'd8;  // combined threshold, beat, result

  typedef struct packed {
    op_t  op;
    logic load_onset;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [DATA_W-1:0] sat32(input logic [DATA_W+1:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W+1:DATA_W] != 2'b00) begin
      r = '1;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/atbp_ctrl.sv
// controller: sequences the shared multiplier over one onset request
module atbp_ctrl
  import atbp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_XA   = 3'd1;
  localparam logic [2:0] ST_MEAN = 3'd2;
  localparam logic [2:0] ST_DA   = 3'd3;
  localparam logic [2:0] ST_DEV  = 3'd4;
  localparam logic [2:0] ST_HELD = 3'd5;
  localparam logic [2:0] ST_DYN  = 3'd6;
  localparam logic [2:0] ST_THR  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.op         = OP_NOP;
    cmd_o.load_onset = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // mean product needs no onset, so it runs while waiting
        in_ready_o       = 1'b1;
        cmd_o.op         = OP_MA;
        cmd_o.load_onset = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_XA;
        end
      end
      ST_XA: begin
        cmd_o.op = OP_XA;
        state_d  = ST_MEAN;
      end
      ST_MEAN: begin
        cmd_o.op = OP_MEAN;
        state_d  = ST_DA;
      end
      ST_DA: begin
        cmd_o.op = OP_DA;
        state_d  = ST_DEV;
      end
      ST_DEV: begin
        cmd_o.op = OP_DEV;
        state_d  = ST_HELD;
      end
      ST_HELD: begin
        cmd_o.op = OP_HELD;
        state_d  = ST_DYN;
      end
      ST_DYN: begin
        cmd_o.op = OP_DYN;
        state_d  = ST_THR;
      end
      ST_THR: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_THR;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/atbp_datapath.sv
// datapath: state registers, shared multiplier, threshold logic and result register
module atbp_datapath
  import atbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic [DATA_W-1:0]  onset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_beat_o,
  output logic [DATA_W-1:0]  out_thr_o
);

  logic [MBI_W-1:0]   mbi_q;
  logic [DECAY_W-1:0] decay_q;

  logic [DATA_W-1:0] mean_q, dev_q, held_q, thr_q, prev_q, older_q;
  logic [HOPS_W-1:0] hops_q;
  logic [DATA_W-1:0] onset_q, dyn_q;
  logic [PROD_W-1:0] p_q, acc_q;

  logic              out_valid_q;
  logic              out_beat_q;
  logic [DATA_W-1:0] out_thr_q;

  logic [DATA_W-1:0] mul_a;
  logic [COEF_W-1:0] mul_b;
  logic [DATA_W-1:0] diff;
  logic [PROD_W:0]   acc_sum;
  logic [DATA_W-1:0] avg_new;
  logic [DATA_W-1:0] pk;
  logic [DATA_W-1:0] thr_new;
  logic [HOPS_W-1:0] hops_inc;
  logic              quiet;
  logic              beat;

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign diff = (onset_q > mean_q) ? (onset_q - mean_q) : (mean_q - onset_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MA: begin
        mul_a = mean_q;
        mul_b = ONE_MIN_A_C;
      end
      OP_XA: begin
        mul_a = onset_q;
        mul_b = ALPHA_C;
      end
      OP_MEAN: begin
        mul_a = dev_q;
        mul_b = ONE_MIN_A_C;
      end
      OP_DA: begin
        mul_a = diff;
        mul_b = ALPHA_C;
      end
      OP_DEV: begin
        mul_a = held_q;
        mul_b = {{(COEF_W-DECAY_W){1'b0}}, decay_q};
      end
      OP_HELD: begin
        mul_a = dev_q;
        mul_b = DEV_C;
      end
      OP_DYN: begin
        mul_a = held_q;
        mul_b = PEAK_C;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ema sum, shifted back to the value format
  assign acc_sum = {1'b0, acc_q} + {1'b0, p_q};
  assign avg_new = sat32(acc_sum[PROD_W:16]);

  assign pk       = p_q[DATA_W+15:16];
  assign quiet    = (mean_q < SMALL_LIMIT) && (onset_q < SMALL_LIMIT);
  assign thr_new  = quiet ? thr_q : ((pk > dyn_q) ? pk : dyn_q);
  assign hops_inc = (hops_q == '1) ? hops_q : hops_q + HOPS_W'(1);
  assign beat     = !quiet && (prev_q > older_q) && (prev_q > onset_q) &&
                    (prev_q > thr_new) &&
                    (hops_inc >= {{(HOPS_W-MBI_W){1'b0}}, mbi_q});

  // payload registers
  always_ff @(posedge clk_i) begin
    // product held while the result step waits for the output register
    if (cmd_i.op != OP_NOP) begin
      p_q <= PROD_W'({{(PROD_W-DATA_W){1'b0}}, mul_a} * {{(PROD_W-COEF_W){1'b0}}, mul_b});
    end
    if (cmd_i.load_onset) begin
      onset_q <= onset_i;
    end
    if (cmd_i.op == OP_XA || cmd_i.op == OP_DA) begin
      acc_q <= p_q;
    end
    if (cmd_i.op == OP_DYN) begin
      dyn_q <= sat32({2'b00, mean_q} + {1'b0, p_q[PROD_W-1:16]});
    end
    if (cmd_i.op == OP_THR) begin
      out_beat_q <= beat;
      out_thr_q  <= thr_new;
    end
  end

  // block state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbi_q       <= MBI_RESET;
      decay_q     <= DECAY_RESET;
      mean_q      <= '0;
      dev_q       <= '0;
      held_q      <= '0;
      thr_q       <= '0;
      prev_q      <= '0;
      older_q     <= '0;
      hops_q      <= {{(HOPS_W-MBI_W){1'b0}}, MBI_RESET};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MBI:   mbi_q   <= cfg_wdata_i[MBI_W-1:0];
          CFG_DECAY: decay_q <= cfg_wdata_i[DECAY_W-1:0];
          default:   mbi_q   <= mbi_q;
        endcase
      end
      if (cmd_i.op == OP_MEAN) begin
        mean_q <= avg_new;
      end
      if (cmd_i.op == OP_DEV) begin
        dev_q <= avg_new;
      end
      if (cmd_i.op == OP_HELD) begin
        held_q <= (onset_q > held_q) ? onset_q : p_q[DATA_W+15:16];
      end
      if (cmd_i.op == OP_THR) begin
        thr_q   <= thr_new;
        older_q <= prev_q;
        prev_q  <= onset_q;
        hops_q  <= beat ? '0 : hops_inc;
      end
      if (cmd_i.op == OP_THR) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;
  assign out_thr_o   = out_thr_q;

endmodule

### sv/adaptive_threshold_beat_picker_top.sv
// top level of the adaptive threshold beat picker: stream ports, controller and datapath
//
// One onset-strength request per analysis hop (unsigned q16.16) goes in on the slave
// stream, and exactly one result comes out on the master stream: the beat flag for the
// previous hop in tuser and the combined threshold in tdata. A request is taken only after
// the last one has left its threshold step, since each request visits the one shared 32x17
// multiplier seven times in turn (mean, deviation, peak decay and the two threshold
// scalings) plus the final threshold step; the result sits in an
// output register, and the next request is taken while it waits, but its own result
// stalls in the last step until the register is free. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle: index 0 is the minimum beat
// interval in hops, index 1 the per-hop decay of the held peak in unsigned q0.16.
module adaptive_threshold_beat_picker_top
  import atbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  // onset requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] onset
  // results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] threshold_level
  output logic              m_axis_tuser    // [0] beat
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer of the per-request steps
  atbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // averages, held peak, history, hop count and the output register
  atbp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .onset_i     (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (m_axis_tuser),
    .out_thr_o   (m_axis_tdata)
  );

  // one request at a time: no second acceptance straight after one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");

  // the threshold step is only issued when the output register can take it
  a_thr_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_THR) |-> stat.out_free)
    else $error("result loaded while output register busy");

  // a result appears only after a threshold step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.op == OP_THR))
    else $error("result valid without threshold step");

endmodule

### sim/adaptive_threshold_beat_picker_top_tb.sv
// self-checking testbench of the adaptive threshold beat picker, stream driver and monitor
module adaptive_threshold_beat_picker_top_tb
  import atbp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result per onset request: beat flag and combined threshold
  typedef struct packed {
    logic              beat;
    logic [DATA_W-1:0] level;
  } beat_result_t;

  localparam int PHASES = 7;

  logic clk_i;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic              cfg_we    = 1'b0;
  logic              cfg_idx   = CFG_MBI;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_valid   = 1'b0;
  logic [DATA_W-1:0] s_data    = '0;
  logic              m_ready   = 1'b1;

  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  // onsets waiting to be sent, and thresholds/beats still owed by the block
  logic [DATA_W-1:0] onset_backlog [$];
  beat_result_t      predicted_beats [$];

  // own copy of the block state and its registers, reset values included
  logic [MBI_W-1:0]   min_gap_q = MBI_RESET;
  logic [DECAY_W-1:0] decay_q   = DECAY_RESET;
  logic [DATA_W-1:0]  mean_q    = '0;
  logic [DATA_W-1:0]  dev_q     = '0;
  logic [DATA_W-1:0]  held_q    = '0;
  logic [DATA_W-1:0]  thr_q     = '0;
  logic [DATA_W-1:0]  prev_q    = '0;
  logic [DATA_W-1:0]  older_q   = '0;
  logic [HOPS_W-1:0]  hops_q    = HOPS_W'(MBI_RESET);

  // handshake pacing, calm switches all idling off for a phase
  bit          calm       = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  int unsigned fail_count   = 0;
  int unsigned requests     = 0;
  int unsigned results_seen = 0;
  int unsigned beats_seen   = 0;
  int unsigned quiet_hops   = 0;

  adaptive_threshold_beat_picker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),         // [31:0] onset
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] threshold_level
    .m_axis_tuser  (m_axis_tuser)    // [0] beat
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // sums beyond 32 bits pin at all ones
  function automatic logic [DATA_W-1:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[DATA_W-1:0];
  endfunction

  // exponential average with alpha 0.08, the sum of products floored
  function automatic logic [DATA_W-1:0] smooth(input logic [DATA_W-1:0] avg,
                                               input logic [DATA_W-1:0] x);
    logic [63:0] acc;
    acc = 64'(avg) * 64'(ONE_MIN_A_C) + 64'(x) * 64'(ALPHA_C);
    return clip32(acc >> 16);
  endfunction

  // advances the state by one hop and returns the result the block owes for it
  function automatic beat_result_t pick_beat(input logic [DATA_W-1:0] onset);
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] dyn;
    logic [DATA_W-1:0] pk;
    beat_result_t      r;
    r.beat = 1'b0;
    if (hops_q != '1) hops_q = hops_q + 1'b1;
    mean_q = smooth(mean_q, onset);
    diff   = (onset > mean_q) ? onset - mean_q : mean_q - onset;
    dev_q  = smooth(dev_q, diff);
    if (onset > held_q) begin
      held_q = onset;
    end else begin
      held_q = DATA_W'((64'(held_q) * 64'(decay_q)) >> 16);
    end
    if (mean_q < SMALL_LIMIT && onset < SMALL_LIMIT) begin
      // quiet signal: threshold kept and no beat; averages, held peak, hop count and history still move
      quiet_hops++;
    end else begin
      dyn   = clip32(64'(mean_q) + ((64'(dev_q) * 64'(DEV_C)) >> 16));
      pk    = DATA_W'((64'(held_q) * 64'(PEAK_C)) >> 16);
      thr_q = (pk > dyn) ? pk : dyn;
      // strict local maximum above threshold, interval elapsed
      if (prev_q > older_q && prev_q > onset && prev_q > thr_q &&
          hops_q >= HOPS_W'(min_gap_q)) begin
        r.beat = 1'b1;
        hops_q = '0;
      end
    end
    older_q = prev_q;
    prev_q  = onset;
    r.level = thr_q;
    return r;
  endfunction

  // appends one onset to the backlog
  function automatic void queue_onset(input logic [DATA_W-1:0] v);
    onset_backlog.insert(onset_backlog.size(), v);
  endfunction

  // ------------------------------------------------------------------
  // driver: bursts of requests from the backlog with random gaps
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_onsets
    logic              nv;
    logic [DATA_W-1:0] nd;
    nv = s_valid;
    nd = s_data;
    if (s_valid && s_axis_tready) begin
      // request taken: predict now, while the state matches the block's
      predicted_beats.insert(predicted_beats.size(), pick_beat(s_data));
      requests++;
      nv = 1'b0;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = 0;
        gap_left   = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      end
    end
    if (!nv && rst_n && onset_backlog.size() != 0) begin
      if (gap_left != 0) begin
        gap_left--;
      end else begin
        if (burst_left == 0) burst_left = $urandom_range(1, 48);
        nv = 1'b1;
        nd = onset_backlog.pop_front();
      end
    end
    s_valid <= nv;
    s_data  <= nd;
  end

  // ------------------------------------------------------------------
  // monitor: checks each result against the oldest prediction, stalls at random
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    beat_result_t want;
    logic         nr;
    if (rst_n && m_axis_tvalid === 1'b1 && m_ready) begin
      results_seen++;
      if (m_axis_tuser === 1'b1) beats_seen++;
      if (predicted_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t unexpected result: expected none, actual beat %b threshold %h",
                   $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = predicted_beats.pop_front();
        if (m_axis_tuser !== want.beat) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t beat mismatch: expected %b actual %b",
                     $time, want.beat, m_axis_tuser);
        end
        if (m_axis_tdata !== want.level) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t threshold mismatch: expected %h actual %h",
                     $time, want.level, m_axis_tdata);
        end
      end
    end
    // receiver stalls at random, none in calm phases
    if (calm) begin
      nr = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      nr = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 19);
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    m_ready <= nr;
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // register write, one cycle of write enable; own copy follows at the same edge
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_MBI) begin
      min_gap_q = val[MBI_W-1:0];
    end else begin
      decay_q = val[DECAY_W-1:0];
    end
  endtask

  // waits until nothing is queued, in flight or owed; sampled at the falling edge
  task automatic wait_idle();
    while (onset_backlog.size() != 0 || s_valid || predicted_beats.size() != 0)
      @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // mostly pulse trains over a low floor, with silence, noise and odd segments
  task automatic queue_onsets(input int unsigned n);
    int unsigned       left;
    int unsigned       run;
    int unsigned       period;
    int unsigned       i;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] floor_v;
    logic [DATA_W-1:0] peak;
    bit                flat;
    left = n;
    while (left > 0) begin
      run  = $urandom_range(8, 64);
      if (run > left) run = left;
      span = 32'hFFFF_FFFF >> $urandom_range(0, 30);
      flat = 1'b0;
      peak = '0;
      case ($urandom_range(0, 9))
        0: begin
          // full-range noise
          for (i = 0; i < run; i++) queue_onset($urandom());
        end
        1: begin
          // silence so the averages can decay into the quiet case
          for (i = 0; i < run; i++) queue_onset('0);
        end
        2: begin
          // unshaped values at one scale
          for (i = 0; i < run; i++) queue_onset($urandom_range(0, span));
        end
        default: begin
          period  = $urandom_range(2, 32);
          floor_v = span >> $urandom_range(2, 6);
          for (i = 0; i < run; i++) begin
            if (i % period == 0) begin
              peak = span - $urandom_range(0, span >> 3);
              flat = ($urandom_range(0, 7) == 0);
              queue_onset(peak);
            end else if (flat) begin
              // flat top, not a strict maximum
              flat = 1'b0;
              queue_onset(peak);
            end else begin
              queue_onset($urandom_range(0, floor_v));
            end
          end
        end
      endcase
      left -= run;
    end
  endtask

  // ------------------------------------------------------------------
  // sequence of the run
  // ------------------------------------------------------------------
  initial begin : run_sequence
    logic [MBI_W-1:0]   gap_set;
    logic [DECAY_W-1:0] decay_set;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part with the reset settings:
    // quiet start, smallest step, a clear beat, a peak inside the interval,
    // saturated flat top, extremes and bit patterns
    onset_backlog = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h0,
                      32'h0001_0000, 32'h0005_0000, 32'h0002_0000,
                      32'h0005_0000, 32'h0009_0000, 32'h0003_0000,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                      32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'h0};
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      calm = 1'b0;
      case (p)
        0: begin gap_set = 10'd6;    decay_set = 16'd63570; end
        1: begin gap_set = 10'd1023; decay_set = 16'hFFFF; calm = 1'b1; end
        2: begin gap_set = 10'd0;    decay_set = 16'd0; end
        3: begin gap_set = 10'd5;    decay_set = 16'd32768; end
        4: begin
          gap_set   = MBI_W'($urandom_range(6, 64));
          decay_set = DECAY_W'($urandom_range(0, 65535));
        end
        5: begin gap_set = 10'd1;    decay_set = 16'd65000; calm = 1'b1; end
        default: begin
          gap_set   = MBI_W'($urandom_range(0, 1023));
          decay_set = DECAY_W'($urandom_range(0, 65535));
        end
      endcase
      // spare upper bits of the interval write carry noise
      write_reg(CFG_MBI, {6'($urandom_range(0, 63)), gap_set});
      write_reg(CFG_DECAY, decay_set);
      repeat (2) @(posedge clk_i);
      queue_onsets(264);
      wait_idle();
    end

    // drained: allow for the block's pipeline once more
    repeat (16) @(posedge clk_i);
    $display("covered %0d onset requests over %0d settings, %0d results checked",
             requests, PHASES + 1, results_seen);
    $display("beats reported: %0d, quiet hops: %0d, failures: %0d",
             beats_seen, quiet_hops, fail_count);
    if (fail_count == 0 && predicted_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", predicted_beats.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
sv/atbp_pkg.sv
sv/atbp_ctrl.sv
sv/atbp_datapath.sv
sv/adaptive_threshold_beat_picker_top.sv
sim/adaptive_threshold_beat_picker_top_tb.sv
